[rtl/utcl_pkg.sv]
// Shared constants, divisor reciprocals and calendar helpers for the
// UTC to Central European local time unit. No dependencies.
package utcl_pkg;

    localparam int UTC_BITS_DEF = 34;
    localparam int REG_UTC_W    = 34;
    localparam int REG_YEAR_W   = 12;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EARLIEST_UTC  = 2'd0,
        CFG_LATEST_UTC    = 2'd1,
        CFG_EARLIEST_YEAR = 2'd2,
        CFG_LATEST_YEAR   = 2'd3
    } cfg_idx_t;

    localparam int EPOCH_SHIFT = 719468;
    localparam int DAYS_ERA    = 146097;
    localparam int DOE_LAST    = 146096;
    localparam int DAYS_4Y     = 1460;
    localparam int DAYS_CENT   = 36524;
    localparam int DAYS_YEAR   = 365;
    localparam int ERA_YEARS   = 400;
    localparam int CENT_YEARS  = 100;
    localparam int JAN_DOY     = 306;
    localparam int MAR31_DOY   = 30;
    localparam int OCT31_OFS   = 214;
    localparam int DAYS_WEEK   = 7;
    localparam int EPOCH_WDAY  = 4;
    localparam int SECS_DAY    = 86400;
    localparam int SECS_HOUR   = 3600;
    localparam int SECS_MIN    = 60;
    localparam int SUMMER_OFF  = 7200;
    localparam int WINTER_OFF  = 3600;
    localparam int DIV_675     = 675;   // 86400 >> 7
    localparam int SOD_SHIFT   = 7;

    // floor(x / d) = (x * M) >> S, exact for x < 2^XW with S = XW + ceil(log2 d)
    localparam int S_675  = 37;
    localparam int S_ERA  = 43;
    localparam int S_7    = 28;
    localparam int S_1460 = 29;
    localparam int S_365  = 27;
    localparam int S_153  = 19;
    localparam int S_3600 = 29;
    localparam int S_60   = 23;

    localparam logic [31:0] M_675  = 32'(((64'd1 << S_675)  + 64'd674)    / 64'd675);
    localparam logic [31:0] M_ERA  = 32'(((64'd1 << S_ERA)  + 64'd146096) / 64'd146097);
    localparam logic [31:0] M_7    = 32'(((64'd1 << S_7)    + 64'd6)      / 64'd7);
    localparam logic [31:0] M_1460 = 32'(((64'd1 << S_1460) + 64'd1459)   / 64'd1460);
    localparam logic [31:0] M_365  = 32'(((64'd1 << S_365)  + 64'd364)    / 64'd365);
    localparam logic [31:0] M_153  = 32'(((64'd1 << S_153)  + 64'd152)    / 64'd153);
    localparam logic [31:0] M_3600 = 32'(((64'd1 << S_3600) + 64'd3599)   / 64'd3600);
    localparam logic [31:0] M_60   = 32'(((64'd1 << S_60)   + 64'd59)     / 64'd60);

    function automatic logic [31:0] mul_shift(input logic [31:0] x, input logic [31:0] m,
                                              input logic [5:0] s);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, m};
        return 32'(p >> s);
    endfunction

    // first March-based day of month mp
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // year of era / 100
    function automatic logic [1:0] yoe_cent(input logic [8:0] yoe);
        return 2'(yoe >= 9'(CENT_YEARS)) + 2'(yoe >= 9'(2 * CENT_YEARS))
             + 2'(yoe >= 9'(3 * CENT_YEARS));
    endfunction

    // day of era / 36524
    function automatic logic [2:0] doe_cent(input logic [17:0] doe);
        return 3'(doe >= 18'(DAYS_CENT)) + 3'(doe >= 18'(2 * DAYS_CENT))
             + 3'(doe >= 18'(3 * DAYS_CENT)) + 3'(doe >= 18'(4 * DAYS_CENT));
    endfunction

endpackage

[rtl/utc_to_local_time_eu_dst_unit.sv]
// UTC second count to Central European local time, summer time included.
// Throughput one beat per cycle while m_ready does not stall the output stage.
// Sixteen register stages with per-stage valid bits; the ready chain lets bubbles fill.
// Reset (aresetn low, synchronous) empties the pipeline and restores the range registers.
// Depends on utcl_pkg.
module utc_to_local_time_eu_dst_unit #(
    parameter int UTC_BITS = utcl_pkg::UTC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [utcl_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [utcl_pkg::REG_UTC_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [UTC_BITS-1:0]                 s_utc_seconds,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_valid_res,
    output logic [11:0]                         m_year,
    output logic [3:0]                          m_month,
    output logic [4:0]                          m_day,
    output logic [4:0]                          m_hour,
    output logic [5:0]                          m_minute,
    output logic [5:0]                          m_second,
    output logic [10:0]                         m_minute_of_day,
    output logic [2:0]                          m_weekday,
    output logic                                m_dst_active
);
    import utcl_pkg::*;

    localparam int NS  = 16;
    localparam int AHW = UTC_BITS - 24;
    localparam int QW1 = (UTC_BITS > 33) ? UTC_BITS - 33 : 1;
    localparam int DW  = QW1 + 17;
    localparam int DW1 = DW + 1;
    localparam int ZW  = (DW >= 20) ? DW + 1 : 21;
    localparam int EW  = ZW - 17;
    localparam int YW  = EW + 9;

    typedef struct packed {
        logic          inr;
        logic [DW-1:0] days;
        logic [16:0]   sod;
        logic [2:0]    wd;
    } side_t;

    typedef struct packed {
        logic [YW-1:0] yr;
        logic [3:0]    month;
        logic [4:0]    day;
    } date_t;

    // configuration
    logic [REG_UTC_W-1:0]  earliest_utc_reg, latest_utc_reg;
    logic [REG_YEAR_W-1:0] earliest_year_reg, latest_year_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            earliest_utc_reg  <= '0;
            latest_utc_reg    <= '1;
            earliest_year_reg <= 12'd1970;
            latest_year_reg   <= 12'd2515;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_EARLIEST_UTC:  earliest_utc_reg  <= cfg_wdata;
                CFG_LATEST_UTC:    latest_utc_reg    <= cfg_wdata;
                CFG_EARLIEST_YEAR: earliest_year_reg <= cfg_wdata[REG_YEAR_W-1:0];
                CFG_LATEST_YEAR:   latest_year_reg   <= cfg_wdata[REG_YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic [NS:1] v_reg;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !v_reg[NS] || m_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_valid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_ready = en[1];
    assign m_valid = v_reg[NS];

    // stage 1: range test, upper quotient digit of t / 86400
    logic [UTC_BITS-1:0] lo, hi;
    logic [AHW-1:0]      ah_next;
    logic [QW1-1:0]      q1_next;
    logic [AHW-1:0]      ah1_reg;
    logic [QW1-1:0]      q1_1_reg;
    logic [16:0]         al1_reg;
    logic [6:0]          tl1_reg;
    logic                inr1_reg;

    assign lo      = UTC_BITS'(earliest_utc_reg);
    assign hi      = UTC_BITS'(latest_utc_reg);
    assign ah_next = s_utc_seconds[UTC_BITS-1:24];
    assign q1_next = QW1'(mul_shift(32'(ah_next), M_675, 6'(S_675)));

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ah1_reg  <= ah_next;
            q1_1_reg <= q1_next;
            al1_reg  <= s_utc_seconds[23:SOD_SHIFT];
            tl1_reg  <= s_utc_seconds[SOD_SHIFT-1:0];
            inr1_reg <= (s_utc_seconds >= lo) && (s_utc_seconds <= hi);
        end
    end

    // stage 2: partial remainder
    logic [9:0]     r1_next;
    logic [26:0]    x2_2_reg;
    logic [QW1-1:0] q1_2_reg;
    logic [6:0]     tl2_reg;
    logic           inr2_reg;

    assign r1_next = 10'(17'(ah1_reg) - 17'(q1_1_reg) * 17'(DIV_675));

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            x2_2_reg <= {r1_next, al1_reg};
            q1_2_reg <= q1_1_reg;
            tl2_reg  <= tl1_reg;
            inr2_reg <= inr1_reg;
        end
    end

    // stage 3: lower quotient digit
    logic [26:0]    x2_3_reg;
    logic [16:0]    q2_3_reg;
    logic [QW1-1:0] q1_3_reg;
    logic [6:0]     tl3_reg;
    logic           inr3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            x2_3_reg <= x2_2_reg;
            q2_3_reg <= 17'(mul_shift(32'(x2_2_reg), M_675, 6'(S_675)));
            q1_3_reg <= q1_2_reg;
            tl3_reg  <= tl2_reg;
            inr3_reg <= inr2_reg;
        end
    end

    // stage 4: day number and second of day
    logic [9:0]    r2_next;
    logic [DW-1:0] days_next;
    logic [DW-1:0] days4_reg;
    logic [16:0]   sod4_reg;
    logic [ZW-1:0] zp4_reg;
    logic          inr4_reg;

    assign r2_next   = 10'(x2_3_reg - 27'(q2_3_reg) * 27'(DIV_675));
    assign days_next = {q1_3_reg, q2_3_reg};

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            days4_reg <= days_next;
            sod4_reg  <= {r2_next, tl3_reg};
            zp4_reg   <= ZW'(days_next) + ZW'(EPOCH_SHIFT);
            inr4_reg  <= inr3_reg;
        end
    end

    // stage 5: era, weekday quotient
    logic [EW-1:0] era5_reg;
    logic [DW-1:0] q7d5_reg;
    logic [ZW-1:0] zp5_reg;
    logic [DW-1:0] days5_reg;
    logic [16:0]   sod5_reg;
    logic          inr5_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            era5_reg  <= EW'(mul_shift(32'(zp4_reg), M_ERA, 6'(S_ERA)));
            q7d5_reg  <= DW'(mul_shift(32'(days4_reg) + 32'(EPOCH_WDAY), M_7, 6'(S_7)));
            zp5_reg   <= zp4_reg;
            days5_reg <= days4_reg;
            sod5_reg  <= sod4_reg;
            inr5_reg  <= inr4_reg;
        end
    end

    // stage 6: day of era; lane 1 is the following day
    logic [17:0]   doe_next;
    logic          wrap_next;
    logic [2:0]    wd_next;
    logic [17:0]   doe6_reg [2];
    logic [EW-1:0] era6_reg [2];
    side_t         side_reg [6:13];

    assign doe_next  = 18'(zp5_reg - ZW'(era5_reg) * ZW'(DAYS_ERA));
    assign wrap_next = (doe_next == 18'(DOE_LAST));
    assign wd_next   = 3'(DW1'(days5_reg) + DW1'(EPOCH_WDAY)
                        - DW1'(q7d5_reg) * DW1'(DAYS_WEEK));

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            doe6_reg[0]      <= doe_next;
            era6_reg[0]      <= era5_reg;
            doe6_reg[1]      <= wrap_next ? 18'd0 : doe_next + 18'd1;
            era6_reg[1]      <= era5_reg + EW'(wrap_next);
            side_reg[6].inr  <= inr5_reg;
            side_reg[6].days <= days5_reg;
            side_reg[6].sod  <= sod5_reg;
            side_reg[6].wd   <= wd_next;
        end
        for (int k = 7; k <= 13; k++) begin
            if (en[k]) side_reg[k] <= side_reg[k-1];
        end
    end

    // stages 7 to 11: civil date per lane
    logic [17:0]   s7_reg   [2];
    logic [17:0]   doe7_reg [2];
    logic [EW-1:0] era7_reg [2];
    logic [8:0]    yoe8_reg [2];
    logic [17:0]   doe8_reg [2];
    logic [EW-1:0] era8_reg [2];
    logic [8:0]    doy9_reg [2];
    logic [8:0]    yoe9_reg [2];
    logic [EW-1:0] era9_reg [2];
    logic [3:0]    mp10_reg [2];
    logic [8:0]    doy10_reg[2];
    logic [YW-1:0] yr10_reg [2];
    logic [8:0]    yy10_reg;
    logic [EW-1:0] eray10_reg;
    logic [9:0]    yp_next;
    logic          yrok_reg [11:13];
    logic [ZW-1:0] zm11_reg, zm12_reg;
    logic [ZW-1:0] q7m12_reg;

    assign yp_next = 10'(yoe9_reg[0]) + 10'(doy9_reg[0] >= 9'(JAN_DOY));

    always_ff @(posedge aclk) begin
        for (int l = 0; l < 2; l++) begin
            if (en[7]) begin
                s7_reg[l]   <= doe6_reg[l]
                               - 18'(mul_shift(32'(doe6_reg[l]), M_1460, 6'(S_1460)))
                               + 18'(doe_cent(doe6_reg[l]))
                               - 18'(doe6_reg[l] == 18'(DOE_LAST));
                doe7_reg[l] <= doe6_reg[l];
                era7_reg[l] <= era6_reg[l];
            end
            if (en[8]) begin
                yoe8_reg[l] <= 9'(mul_shift(32'(s7_reg[l]), M_365, 6'(S_365)));
                doe8_reg[l] <= doe7_reg[l];
                era8_reg[l] <= era7_reg[l];
            end
            if (en[9]) begin
                doy9_reg[l] <= 9'(doe8_reg[l] - (18'(yoe8_reg[l]) * 18'(DAYS_YEAR)
                               + 18'(yoe8_reg[l] >> 2) - 18'(yoe_cent(yoe8_reg[l]))));
                yoe9_reg[l] <= yoe8_reg[l];
                era9_reg[l] <= era8_reg[l];
            end
            if (en[10]) begin
                mp10_reg[l]  <= 4'(mul_shift(32'({doy9_reg[l], 2'b00}) + 32'(doy9_reg[l])
                                   + 32'd2, M_153, 6'(S_153)));
                doy10_reg[l] <= doy9_reg[l];
                yr10_reg[l]  <= YW'(era9_reg[l]) * YW'(ERA_YEARS) + YW'(yoe9_reg[l])
                                + YW'(doy9_reg[l] >= 9'(JAN_DOY));
            end
        end
        if (en[10]) begin
            yy10_reg   <= (yp_next == 10'(ERA_YEARS)) ? 9'd0 : 9'(yp_next);
            eray10_reg <= era9_reg[0] + EW'(yp_next == 10'(ERA_YEARS));
        end
    end

    // stage 11: month and day per lane, range test on UTC year, day of March 31
    date_t date11_next [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            date11_next[l].yr    = yr10_reg[l];
            date11_next[l].day   = 5'(doy10_reg[l] - month_start(mp10_reg[l]) + 9'd1);
            date11_next[l].month = (mp10_reg[l] < 4'd10) ? mp10_reg[l] + 4'd3
                                                          : mp10_reg[l] - 4'd9;
        end
    end

    date_t lane_reg [11:13][2];

    always_ff @(posedge aclk) begin
        if (en[11]) begin
            lane_reg[11][0] <= date11_next[0];
            lane_reg[11][1] <= date11_next[1];
            yrok_reg[11]    <= (yr10_reg[0] >= YW'(earliest_year_reg))
                               && (yr10_reg[0] <= YW'(latest_year_reg));
            zm11_reg        <= ZW'(ZW'(eray10_reg) * ZW'(DAYS_ERA)
                               + ZW'(yy10_reg) * ZW'(DAYS_YEAR) + ZW'(yy10_reg >> 2)
                               - ZW'(yoe_cent(yy10_reg)) + ZW'(MAR31_DOY)
                               - ZW'(EPOCH_SHIFT));
        end
        for (int k = 12; k <= 13; k++) begin
            if (en[k]) begin
                lane_reg[k] <= lane_reg[k-1];
                yrok_reg[k] <= yrok_reg[k-1];
            end
        end
        if (en[12]) begin
            q7m12_reg <= ZW'(mul_shift(32'(zm11_reg) + 32'(EPOCH_WDAY), M_7, 6'(S_7)));
            zm12_reg  <= zm11_reg;
        end
    end

    // stage 13: switch days (last Sundays of March and October)
    logic [2:0]    wm_next, wo_next;
    logic [ZW-1:0] ds13_reg, do13_reg;

    assign wm_next = 3'(zm12_reg + ZW'(EPOCH_WDAY) - q7m12_reg * ZW'(DAYS_WEEK));
    assign wo_next = (wm_next >= 3'd3) ? wm_next - 3'd3 : wm_next + 3'd4;

    always_ff @(posedge aclk) begin
        if (en[13]) begin
            ds13_reg <= zm12_reg - ZW'(wm_next);
            do13_reg <= zm12_reg + ZW'(OCT31_OFS) - ZW'(wo_next);
        end
    end

    // stage 14: offset, day carry, lane select
    side_t         sd;
    logic [ZW-1:0] zd;
    logic          summer_next, carry_next;
    logic [17:0]   ls_raw;
    logic          ok14_reg, dst14_reg;
    logic [16:0]   ls14_reg;
    date_t         date14_reg;
    logic [2:0]    wday14_reg;

    assign sd          = side_reg[13];
    assign zd          = ZW'(sd.days);
    assign summer_next = ((zd > ds13_reg) || (zd == ds13_reg && sd.sod >= 17'(SECS_HOUR)))
                      && ((zd < do13_reg) || (zd == do13_reg && sd.sod < 17'(SECS_HOUR)));
    assign ls_raw      = 18'(sd.sod) + (summer_next ? 18'(SUMMER_OFF) : 18'(WINTER_OFF));
    assign carry_next  = (ls_raw >= 18'(SECS_DAY));

    always_ff @(posedge aclk) begin
        if (en[14]) begin
            ok14_reg   <= sd.inr && yrok_reg[13];
            dst14_reg  <= summer_next;
            ls14_reg   <= 17'(carry_next ? ls_raw - 18'(SECS_DAY) : ls_raw);
            date14_reg <= carry_next ? lane_reg[13][1] : lane_reg[13][0];
            wday14_reg <= !carry_next ? sd.wd
                        : (sd.wd == 3'(DAYS_WEEK - 1)) ? 3'd0 : sd.wd + 3'd1;
        end
    end

    // stage 15: hour and minute of day
    logic          ok15_reg, dst15_reg;
    logic [16:0]   ls15_reg;
    logic [4:0]    hr15_reg;
    logic [10:0]   mod15_reg;
    date_t         date15_reg;
    logic [2:0]    wday15_reg;

    always_ff @(posedge aclk) begin
        if (en[15]) begin
            ok15_reg   <= ok14_reg;
            dst15_reg  <= dst14_reg;
            ls15_reg   <= ls14_reg;
            hr15_reg   <= 5'(mul_shift(32'(ls14_reg), M_3600, 6'(S_3600)));
            mod15_reg  <= 11'(mul_shift(32'(ls14_reg), M_60, 6'(S_60)));
            date15_reg <= date14_reg;
            wday15_reg <= wday14_reg;
        end
    end

    // stage 16: output register
    always_ff @(posedge aclk) begin
        if (en[16]) begin
            m_valid_res     <= ok15_reg;
            m_year          <= ok15_reg ? 12'(date15_reg.yr) : 12'd0;
            m_month         <= ok15_reg ? date15_reg.month : 4'd0;
            m_day           <= ok15_reg ? date15_reg.day : 5'd0;
            m_hour          <= ok15_reg ? hr15_reg : 5'd0;
            m_minute        <= ok15_reg ? 6'(mod15_reg - 11'(hr15_reg) * 11'(SECS_MIN)) : 6'd0;
            m_second        <= ok15_reg ? 6'(ls15_reg - 17'(mod15_reg) * 17'(SECS_MIN)) : 6'd0;
            m_minute_of_day <= ok15_reg ? mod15_reg : 11'd0;
            m_weekday       <= ok15_reg ? wday15_reg : 3'd0;
            m_dst_active    <= ok15_reg && dst15_reg;
        end
    end

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_year == 12'd0 && m_month == 4'd0 && m_day == 5'd0
            && m_minute_of_day == 11'd0 && !m_dst_active)
        else $error("out-of-range beat carries nonzero fields");

    a_fields_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_month >= 4'd1 && m_month <= 4'd12 && m_day >= 5'd1
            && m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59 && m_weekday <= 3'd6)
        else $error("local time field out of range");

    a_minute_of_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_minute_of_day == 11'(m_hour) * 11'd60 + 11'(m_minute))
        else $error("minute of day disagrees with hour and minute");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &v_reg)
        else $error("input stalled while pipeline has a bubble");

endmodule
